[src/dqvs_pkg.sv]
// Shared types and codes for the searchable deque.
package dqvs_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CONTAINS   = 3'd4,
    CMD_REMOVE     = 3'd5
  } dqvs_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } dqvs_status_t;

  // One-hot operation strobes broadcast to every cell, already gated by
  // accept and, for pushes and pops, by the full and empty checks.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic remove;
  } dqvs_ctrl_t;

endpackage

[src/deque_with_value_search.sv]
// Top level of the bounded deque with value search.
// A bounded deque of DEPTH signed words held in a row of cells, cell 0 at the
// front. Every command (push or pop at either end, contains, remove first
// match from the front) acts on the whole row: all cells compare against the
// word and shift toward or away from the front in the same edge, with the
// first-match flag rippling from the front cell to the back. busy stays low,
// so a command may be given on every cycle. The result word appears for
// exactly one cycle, marked by out_valid, in the cycle after the command is
// taken, and shows the state after that command; it must be taken then.
// Pushes on a full deque, pops on an empty one and removes without a match
// are flagged in out_status and leave the contents unchanged.
module deque_with_value_search #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic signed [31:0] out_front_value,
  output logic signed [31:0] out_back_value,
  output logic               out_is_empty,
  output logic [4:0]         out_count
);
  import dqvs_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                   accept;
  logic [VALUE_WIDTH-1:0] key;
  logic signed [63:0]     in_ext;
  dqvs_ctrl_t             ctrl;
  logic                   full, empty;

  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic                   cell_valid [DEPTH];
  logic                   match_chain [DEPTH+1];

  logic [CNT_W-1:0]       count_r, count_nxt;
  dqvs_status_t           status_r, status_nxt;
  logic                   found_r, found_nxt;
  logic                   out_valid_r;

  logic [VALUE_WIDTH-1:0] back_word;
  logic signed [63:0]     front_ext, back_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign in_ext = 64'(in_value);
  assign key    = in_ext[VALUE_WIDTH-1:0];
  assign full   = cell_valid[DEPTH-1];
  assign empty  = !cell_valid[0];

  assign match_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_value, next_value;
    logic                   prev_valid, next_valid;
    if (i == 0) begin : g_head
      assign prev_value = key;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end
    dqvs_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .key        (key),
      .prev_value (prev_value),
      .prev_valid (prev_valid),
      .next_value (next_value),
      .next_valid (next_valid),
      .match_in   (match_chain[i]),
      .match_out  (match_chain[i+1]),
      .value      (cell_value[i]),
      .valid      (cell_valid[i])
    );
  end

  always_comb begin
    ctrl       = '0;
    status_nxt = ST_OK;
    found_nxt  = 1'b0;
    count_nxt  = count_r;
    case (dqvs_cmd_t'(in_cmd))
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.push_front = accept && (in_cmd == CMD_PUSH_FRONT);
          ctrl.push_back  = accept && (in_cmd == CMD_PUSH_BACK);
          count_nxt       = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.pop_front = accept && (in_cmd == CMD_POP_FRONT);
          ctrl.pop_back  = accept && (in_cmd == CMD_POP_BACK);
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      CMD_CONTAINS: begin
        found_nxt = match_chain[DEPTH];
      end
      CMD_REMOVE: begin
        found_nxt   = match_chain[DEPTH];
        ctrl.remove = accept;
        if (match_chain[DEPTH]) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
    end
  end

  // The back entry is the one valid cell whose successor is empty.
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && ((i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH])) begin
        back_word = back_word | cell_value[i];
      end
    end
  end

  assign front_ext = 64'($signed(cell_value[0]));
  assign back_ext  = 64'($signed(back_word));

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_is_empty    = empty;
  assign out_front_value = empty ? 32'sd0 : front_ext[31:0];
  assign out_back_value  = empty ? 32'sd0 : back_ext[31:0];
  assign out_count       = 5'(count_r);

endmodule

[src/dqvs_cell.sv]
// One storage cell of the deque chain: holds a word and its valid flag.
module dqvs_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dqvs_pkg::dqvs_ctrl_t   ctrl,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [VALUE_WIDTH-1:0] prev_value,
  input  logic                   prev_valid,
  input  logic [VALUE_WIDTH-1:0] next_value,
  input  logic                   next_valid,
  input  logic                   match_in,
  output logic                   match_out,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   valid
);
  import dqvs_pkg::*;

  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   valid_r, valid_nxt;
  logic                   hit;

  assign hit       = valid_r && (value_r == key);
  assign match_out = match_in || hit;
  assign value     = value_r;
  assign valid     = valid_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctrl.push_front) begin
      value_nxt = prev_value;
      valid_nxt = prev_valid;
    end else if (ctrl.push_back) begin
      // The first empty cell behind a valid one takes the new word.
      if (prev_valid && !valid_r) begin
        value_nxt = key;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.pop_front) begin
      value_nxt = next_value;
      valid_nxt = next_valid;
    end else if (ctrl.pop_back) begin
      if (valid_r && !next_valid) begin
        valid_nxt = 1'b0;
      end
    end else if (ctrl.remove) begin
      // Every cell at or behind the first match closes the gap.
      if (match_out) begin
        value_nxt = next_value;
        valid_nxt = next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[src/dqvs_checker.sv]
// Port-level checks for the searchable deque, bound to its top level.
module dqvs_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [1:0]         out_status,
  input logic               out_found,
  input logic signed [31:0] out_front_value,
  input logic signed [31:0] out_back_value,
  input logic               out_is_empty,
  input logic [4:0]         out_count
);
  import dqvs_pkg::*;

  // Every word taken gets exactly one result on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy))
    else $error("result strobe does not follow the accepted word");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == 5'd0)))
    else $error("empty flag disagrees with count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_front_value == 32'sd0 && out_back_value == 32'sd0))
    else $error("empty deque reports nonzero entries");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_count == 5'(DEPTH) && !out_found))
    else $error("full status without a full deque");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NOT_FOUND || out_status == ST_EMPTY)) |-> !out_found)
    else $error("found flag set on a failed command");

endmodule

bind deque_with_value_search dqvs_checker #(.DEPTH(DEPTH)) u_dqvs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_front_value (out_front_value),
  .out_back_value  (out_back_value),
  .out_is_empty    (out_is_empty),
  .out_count       (out_count)
);
